@@ hdl/psd_pkg.sv @@
// package for the plot stream decoder: record type, command and kind codes
// no dependencies; imported by every module of the decoder
package psd_pkg;

    localparam int QUEUE_DEPTH = 4;

    // command codes
    localparam logic [3:0] CMD_M = 4'd0;
    localparam logic [3:0] CMD_L = 4'd1;
    localparam logic [3:0] CMD_T = 4'd2;
    localparam logic [3:0] CMD_E = 4'd3;
    localparam logic [3:0] CMD_P = 4'd4;
    localparam logic [3:0] CMD_N = 4'd5;
    localparam logic [3:0] CMD_S = 4'd6;
    localparam logic [3:0] CMD_A = 4'd7;
    localparam logic [3:0] CMD_C = 4'd8;
    localparam logic [3:0] CMD_F = 4'd9;
    localparam logic [3:0] CMD_D = 4'd10;

    // record kinds
    localparam logic [1:0] KIND_BARE     = 2'd0;
    localparam logic [1:0] KIND_OPERAND  = 2'd1;
    localparam logic [1:0] KIND_TEXT_CHR = 2'd2;
    localparam logic [1:0] KIND_TEXT_END = 2'd3;

    typedef struct packed {
        logic [3:0]         command;
        logic [1:0]         kind;
        logic [15:0]        operand_index;
        logic signed [15:0] value;
        logic               last;
    } t_rec;

endpackage

@@ hdl/plot_stream_decoder_unit.sv @@
// top level of the plot stream decoder: front end, record queue, output stage
// depends on psd_pkg, psd_front, psd_queue, psd_back
//
//  channel   direction  handshake             payload
//  stream    in         i_valid / o_ready     i_stream_byte
//  record    out        o_valid / i_ready     o_command, o_kind, o_operand_index,
//                                             o_value, o_last
//
// one stream byte is taken per cycle while o_ready is high; a byte that ends a
// record pushes it into the queue on acceptance; the output stage then loads it.
// o_ready drops only when the record queue is full, so a stalled output
// backs up through DEPTH queue entries plus the output register.
// synchronous active-low reset empties the queue and returns the parser to idle.
module plot_stream_decoder_unit #(
    parameter int DEPTH = psd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_stream_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_command,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_operand_index,
    output logic signed [15:0] o_value,
    output logic               o_last
);
    import psd_pkg::*;

    logic push, full, pop, empty;
    t_rec front_rec, queue_rec, out_rec;

    psd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_stream_byte(i_stream_byte),
        .i_queue_full (full),
        .o_push       (push),
        .o_rec        (front_rec)
    );

    psd_queue #(
        .DEPTH(DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_rec  (front_rec),
        .o_full (full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_rec  (queue_rec)
    );

    psd_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_empty(empty),
        .i_rec  (queue_rec),
        .o_pop  (pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rec  (out_rec)
    );

    assign o_command       = out_rec.command;
    assign o_kind          = out_rec.kind;
    assign o_operand_index = out_rec.operand_index;
    assign o_value         = out_rec.value;
    assign o_last          = out_rec.last;

endmodule

@@ hdl/psd_front.sv @@
// front end: takes stream bytes, tracks command parsing state, builds records
// depends on psd_pkg
module psd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_queue_full,
    output logic          o_push,
    output psd_pkg::t_rec o_rec
);
    import psd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_TEXT = 2'd3
    } t_phase;

    localparam logic [7:0] CH_M  = 8'h6d;
    localparam logic [7:0] CH_L  = 8'h6c;
    localparam logic [7:0] CH_T  = 8'h74;
    localparam logic [7:0] CH_E  = 8'h65;
    localparam logic [7:0] CH_P  = 8'h70;
    localparam logic [7:0] CH_N  = 8'h6e;
    localparam logic [7:0] CH_S  = 8'h73;
    localparam logic [7:0] CH_A  = 8'h61;
    localparam logic [7:0] CH_C  = 8'h63;
    localparam logic [7:0] CH_F  = 8'h66;
    localparam logic [7:0] CH_D  = 8'h64;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_NUL = 8'h00;

    t_phase      r_phase, n_phase;
    logic [3:0]  r_cmd, n_cmd;
    logic [7:0]  r_low, n_low;
    logic [15:0] r_count, n_count;
    logic [15:0] r_needed, n_needed;

    logic        accept;
    logic        hit;
    logic [3:0]  dec_code;
    logic [15:0] dec_count;
    logic [15:0] word;
    logic [15:0] needed_eff;
    logic [16:0] next_idx;
    logic        is_last;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign word    = {i_stream_byte, r_low};

    always_comb begin
        hit       = 1'b1;
        dec_code  = CMD_M;
        dec_count = 16'd0;
        unique case (i_stream_byte)
            CH_M: begin dec_code = CMD_M; dec_count = 16'd2; end
            CH_L: begin dec_code = CMD_L; dec_count = 16'd4; end
            CH_T: begin dec_code = CMD_T; dec_count = 16'd0; end
            CH_E: begin dec_code = CMD_E; dec_count = 16'd0; end
            CH_P: begin dec_code = CMD_P; dec_count = 16'd2; end
            CH_N: begin dec_code = CMD_N; dec_count = 16'd2; end
            CH_S: begin dec_code = CMD_S; dec_count = 16'd4; end
            CH_A: begin dec_code = CMD_A; dec_count = 16'd6; end
            CH_C: begin dec_code = CMD_C; dec_count = 16'd3; end
            CH_F: begin dec_code = CMD_F; dec_count = 16'd0; end
            CH_D: begin dec_code = CMD_D; dec_count = 16'd4; end
            default: hit = 1'b0;
        endcase
    end

    // dot pattern count comes from the fourth operand when positive
    always_comb begin
        needed_eff = r_needed;
        if (r_cmd == CMD_D && r_count == 16'd3) begin
            if (!word[15] && word != 16'd0) begin
                needed_eff = 16'd4 + word;
            end else begin
                needed_eff = 16'd4;
            end
        end
        next_idx = {1'b0, r_count} + 17'd1;
        is_last  = next_idx >= {1'b0, needed_eff};
    end

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_low    = r_low;
        n_count  = r_count;
        n_needed = r_needed;
        o_push   = 1'b0;
        o_rec    = '{command: r_cmd, kind: KIND_BARE, operand_index: 16'd0,
                     value: 16'sd0, last: 1'b0};
        if (accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (hit) begin
                        n_cmd    = dec_code;
                        n_count  = 16'd0;
                        n_needed = dec_count;
                        if (dec_code == CMD_E) begin
                            o_push = 1'b1;
                            o_rec  = '{command: dec_code, kind: KIND_BARE,
                                       operand_index: 16'd0, value: 16'sd0,
                                       last: 1'b1};
                        end else if (dec_count == 16'd0) begin
                            n_phase = PH_TEXT;
                        end else begin
                            n_phase = PH_LOW;
                        end
                    end
                end
                PH_LOW: begin
                    n_low   = i_stream_byte;
                    n_phase = PH_HIGH;
                end
                PH_HIGH: begin
                    n_needed = needed_eff;
                    o_push   = 1'b1;
                    o_rec    = '{command: r_cmd, kind: KIND_OPERAND,
                                 operand_index: r_count, value: word,
                                 last: is_last};
                    n_count  = next_idx[15:0];
                    n_phase  = is_last ? PH_IDLE : PH_LOW;
                end
                PH_TEXT: begin
                    o_push = 1'b1;
                    if (i_stream_byte == CH_LF || i_stream_byte == CH_NUL) begin
                        o_rec   = '{command: r_cmd, kind: KIND_TEXT_END,
                                    operand_index: r_count,
                                    value: {8'd0, i_stream_byte}, last: 1'b1};
                        n_phase = PH_IDLE;
                    end else begin
                        o_rec = '{command: r_cmd, kind: KIND_TEXT_CHR,
                                  operand_index: r_count,
                                  value: {8'd0, i_stream_byte}, last: 1'b0};
                        // index saturates on very long text
                        if (r_count != 16'hffff) begin
                            n_count = next_idx[15:0];
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_cmd    <= CMD_M;
            r_low    <= 8'd0;
            r_count  <= 16'd0;
            r_needed <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_low    <= n_low;
            r_count  <= n_count;
            r_needed <= n_needed;
        end
    end

endmodule

@@ hdl/psd_queue.sv @@
// short record queue between the front end and the output stage
// depends on psd_pkg
module psd_queue #(
    parameter int DEPTH = psd_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psd_pkg::t_rec i_rec,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output psd_pkg::t_rec o_rec
);
    import psd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_rec          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == FULL_CNT;
    assign o_empty = r_cnt == '0;
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

endmodule

@@ hdl/psd_back.sv @@
// output stage: pulls records from the queue into the output register
// depends on psd_pkg
module psd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  psd_pkg::t_rec i_rec,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output psd_pkg::t_rec o_rec
);
    import psd_pkg::*;

    logic r_valid, n_valid;
    t_rec r_rec;

    // refill whenever the held beat leaves or the register is empty
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_rec   = r_rec;

    always_comb begin
        n_valid = r_valid;
        if (o_pop) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule
